### hw/rtl/mrwt_pkg.sv
// mrwt_pkg: shared types and codes for the miller-rabin witness test
// no dependencies
`timescale 1ns / 1ps
package mrwt_pkg;
  localparam int WIDTH = 32;
  localparam int KW = 6;
  localparam logic [1:0] VERDICT_PRIME = 2'd0;
  localparam logic [1:0] VERDICT_FACTOR = 2'd1;
  localparam logic [1:0] VERDICT_NOFACT = 2'd2;

  typedef logic [WIDTH-1:0] word_t;

  typedef struct packed {
    logic start;
    word_t x;
    word_t y;
  } mul_req_t;
endpackage

### hw/rtl/miller_rabin_witness_test.sv
// miller_rabin_witness_test: one miller-rabin round with factor report
// depends on mrwt_pkg and mrwt_mulmod
`timescale 1ns / 1ps
// Each transaction runs alone: base is reduced by a restoring divider (one quotient bit
// a cycle), then a right-to-left square-and-multiply exponentiation and up to k-1
// squarings go through one shared shift-add modular multiplier, and a binary gcd
// finishes a composite. The result waits in an output register.
module miller_rabin_witness_test import mrwt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] candidate,
  input  logic [31:0] base,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  verdict,
  output logic [31:0] factor
);
  localparam logic [3:0] S_IDLE = 4'd0, S_RED = 4'd1, S_CHK = 4'd2, S_EXP = 4'd3,
    S_EXPW = 4'd4, S_TST = 4'd5, S_SQ = 4'd6, S_SQW = 4'd7, S_GCD = 4'd8, S_OUT = 4'd9,
    S_EXPX = 4'd10;
  localparam int CW = $clog2(WIDTH);

  logic [3:0] state;
  word_t n, a, m, b, r, prev, ga, gb, rem;
  logic [KW-1:0] k, i;
  logic [CW-1:0] cnt;
  logic phase;
  mul_req_t req;
  logic mdone;
  word_t prod;
  logic [WIDTH:0] rsh;

  mrwt_mulmod u_mul (.clk, .rst, .req, .n, .done(mdone), .prod);

  assign in_stall = (state != S_IDLE) || out_valid;
  assign rsh = {rem, a[WIDTH-1]};

  always_ff @(posedge clk) begin
    req.start <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid && !in_stall) begin
          n <= candidate[WIDTH-1:0];
          a <= base[WIDTH-1:0];
          rem <= '0;
          cnt <= '0;
          if (!candidate[0]) begin
            verdict <= VERDICT_FACTOR; factor <= 32'd2; state <= S_OUT;
          end else if (candidate[WIDTH-1:0] == WIDTH'(1)) begin
            verdict <= VERDICT_NOFACT; factor <= '0; state <= S_OUT;
          end else begin
            m <= candidate[WIDTH-1:0] - 1'b1;
            k <= '0;
            state <= S_RED;
          end
        end
        S_RED: begin
          // restoring division, a shifts into rem
          a <= {a[WIDTH-2:0], 1'b0};
          rem <= (rsh >= {1'b0, n}) ? WIDTH'(rsh - {1'b0, n}) : rsh[WIDTH-1:0];
          if (!m[0]) begin m <= m >> 1; k <= k + 1'b1; end
          cnt <= cnt + 1'b1;
          if (cnt == CW'(WIDTH - 1)) state <= S_CHK;
        end
        S_CHK: begin
          if (!m[0]) begin
            m <= m >> 1; k <= k + 1'b1;
          end else if (rem == '0) begin
            verdict <= VERDICT_NOFACT; factor <= '0; state <= S_OUT;
          end else begin
            a <= rem; r <= WIDTH'(1); state <= S_EXP;
          end
        end
        S_EXP: begin
          if (m == '0) begin
            b <= r; i <= '0; state <= S_TST;
          end else begin
            phase <= 1'b0;
            if (m[0]) begin
              req.start <= 1'b1; req.x <= r; req.y <= a; state <= S_EXPW;
            end else begin
              phase <= 1'b1; req.start <= 1'b1; req.x <= a; req.y <= a; state <= S_EXPW;
            end
          end
        end
        S_EXPW: if (mdone) begin
          if (!phase) begin
            r <= prod; phase <= 1'b1;
            state <= S_EXPX;
          end else begin
            a <= prod; m <= m >> 1; state <= S_EXP;
          end
        end
        S_EXPX: begin
          req.start <= 1'b1; req.x <= a; req.y <= a; state <= S_EXPW;
        end
        S_TST: begin
          if (b == WIDTH'(1) || b == n - 1'b1) begin
            verdict <= VERDICT_PRIME; factor <= '0; state <= S_OUT;
          end else begin
            prev <= b; state <= S_SQ;
          end
        end
        S_SQ: begin
          if (KW'(i + 1'b1) < k) begin
            req.start <= 1'b1; req.x <= b; req.y <= b; state <= S_SQW;
          end else begin
            ga <= (prev == '0) ? n - 1'b1 : prev - 1'b1; gb <= n; state <= S_GCD;
          end
        end
        S_SQW: if (mdone) begin
          i <= i + 1'b1;
          if (prod == WIDTH'(1)) begin
            ga <= (prev == '0) ? n - 1'b1 : prev - 1'b1; gb <= n; state <= S_GCD;
          end else if (prod == n - 1'b1) begin
            verdict <= VERDICT_PRIME; factor <= '0; state <= S_OUT;
          end else begin
            b <= prod; prev <= prod; state <= S_SQ;
          end
        end
        S_GCD: begin
          // binary gcd; gb stays odd because n is odd, gcd lands in gb once ga is zero
          if (ga == '0) begin
            if (gb > WIDTH'(1) && gb < n) begin
              verdict <= VERDICT_FACTOR; factor <= 32'(gb);
            end else begin
              verdict <= VERDICT_NOFACT; factor <= '0;
            end
            state <= S_OUT;
          end else if (!ga[0]) begin
            ga <= ga >> 1;
          end else if (ga >= gb) begin
            ga <= ga - gb;
          end else begin
            ga <= gb - ga; gb <= ga;
          end
        end
        S_OUT: begin
          out_valid <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### hw/rtl/mrwt_mulmod.sv
// mrwt_mulmod: shift-add modular multiplier, one bit of y per cycle
// depends on mrwt_pkg
`timescale 1ns / 1ps
module mrwt_mulmod import mrwt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  input  word_t    n,
  output logic     done,
  output word_t    prod
);
  localparam int CW = $clog2(WIDTH);
  logic busy;
  logic [CW-1:0] cnt;
  word_t x, y, acc;
  logic [WIDTH:0] dbl, sum;
  word_t a1, a2;

  always_comb begin
    dbl = {acc, 1'b0};
    a1 = (dbl >= {1'b0, n}) ? WIDTH'(dbl - {1'b0, n}) : dbl[WIDTH-1:0];
    sum = {1'b0, a1} + {1'b0, x};
    a2 = y[WIDTH-1] ? ((sum >= {1'b0, n}) ? WIDTH'(sum - {1'b0, n}) : sum[WIDTH-1:0]) : a1;
  end

  assign prod = acc;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
      x <= req.x;
      y <= req.y;
      acc <= '0;
      cnt <= '0;
    end else if (busy) begin
      acc <= a2;
      y <= {y[WIDTH-2:0], 1'b0};
      cnt <= cnt + 1'b1;
      if (cnt == CW'(WIDTH - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule
